// ===== rtl/core/svm_pkg.sv =====
package svm_pkg;

  localparam int unsigned MaxVoices = 48;
  localparam int unsigned NumSounds = 16;
  localparam int unsigned WaveWords = 65536;

  localparam int unsigned VoiceW = $clog2(MaxVoices);
  localparam int unsigned CountW = $clog2(MaxVoices + 1);
  localparam int unsigned SoundW = $clog2(NumSounds);
  localparam int unsigned WaveAw = $clog2(WaveWords);
  localparam int unsigned PosW   = 17;

  // Configuration register indexes
  localparam logic [1:0] RegMute    = 2'd0;
  localparam logic [1:0] RegLimit   = 2'd1;
  localparam logic [1:0] RegRetrig  = 2'd2;
  localparam logic [1:0] RegClip    = 2'd3;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [5:0]  ResetVoiceLimit = 6'd48;
  localparam logic [15:0] ResetRetrig     = 16'd128;
  localparam logic [14:0] ResetClip       = 15'd32760;

  // Command codes
  localparam logic [1:0] CmdTick  = 2'd0;
  localparam logic [1:0] CmdPlay  = 2'd1;
  localparam logic [1:0] CmdWave  = 2'd2;
  localparam logic [1:0] CmdSound = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  sound_id;
    logic [15:0] wave_addr;
    logic signed [15:0] wave_value;
    logic [15:0] sound_start;
    logic [15:0] sound_length;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] mixed_sample;
    logic        play_accepted;
    logic [5:0]  active_voices;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic              load;       // capture input word
    logic              clr_sum;
    logic              scan_rd;    // read voice slot into pipeline
    logic [VoiceW-1:0] scan_idx;
    logic              tick_upd;   // wave word arrived: accumulate and advance
    logic              play_chk;   // check slot for retrigger and free
    logic              do_start;   // commit found free slot
    logic              do_writes;  // wave or descriptor write
    logic              make_out;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       tick_skip;
    logic       play_refuse;
  } dp_stat_t;

endpackage

// ===== rtl/core/svm_if.sv =====
interface svm_if #(type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/saturating_voice_mixer_core.sv =====
// Sample-playback mixer with 48 voices. Each item takes one word and gives one
// result word. An unmuted tick with voices active walks every voice slot
// through a two-stage scan (slot read, then wave memory read), one slot per
// cycle. An admissible play request scans the slots too (retrigger check and
// lowest free slot) and then commits the slot unless a retrigger is refused.
// Wave and descriptor writes and refused or silent items skip the scan. The
// input is taken again once the previous result has been handed over; a
// stalled receiver adds its stall. Configuration is written on the plain write
// port while the block is idle: a rule for the user, not enforced by the block.
module saturating_voice_mixer_core
  import svm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  svm_if.sink                 in_if,
  svm_if.source               out_if,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic        mute_q;
  logic [5:0]  limit_q;
  logic [15:0] retrig_q;
  logic [14:0] clip_q;
  dp_cmd_t     dcmd;
  dp_stat_t    dstat;
  out_word_t   res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mute_q   <= 1'b0;
      limit_q  <= ResetVoiceLimit;
      retrig_q <= ResetRetrig;
      clip_q   <= ResetClip;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMute:   mute_q   <= cfg_data_i[0];
        RegLimit:  limit_q  <= cfg_data_i[5:0];
        RegRetrig: retrig_q <= cfg_data_i[15:0];
        RegClip:   clip_q   <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  svm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .stat_i     (dstat),
    .cmd_o      (dcmd)
  );

  svm_datapath u_dp (
    .clk_i, .rst_ni,
    .in_i    (in_if.data),
    .cmd_i   (dcmd),
    .mute_i  (mute_q),
    .limit_i (limit_q),
    .retrig_i(retrig_q),
    .clip_i  (clip_q),
    .stat_o  (dstat),
    .out_o   (res)
  );

  assign out_if.data = res;

endmodule

// ===== rtl/core/svm_datapath.sv =====
module svm_datapath
  import svm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  in_word_t            in_i,
  input  dp_cmd_t             cmd_i,
  input  logic                mute_i,
  input  logic [5:0]          limit_i,
  input  logic [15:0]         retrig_i,
  input  logic [14:0]         clip_i,
  output dp_stat_t            stat_o,
  output out_word_t           out_o
);

  in_word_t item_q;

  // voice state: busy flags in flops, sound and position in slot memory
  logic [MaxVoices-1:0] busy_q;
  logic [SoundW-1:0]    vsnd_q [MaxVoices];
  logic [PosW-1:0]      vpos_q [MaxVoices];
  logic [CountW-1:0]    count_q;

  // sound descriptors
  logic [15:0]          base_q [NumSounds];
  logic [15:0]          size_q [NumSounds];
  logic [NumSounds-1:0] def_q;

  // wave memory
  logic signed [15:0] wave_mem [WaveWords];
  logic signed [15:0] wave_rd_q;

  // scan pipeline, first stage: slot read
  logic              s_busy_q;
  logic [VoiceW-1:0] s_idx_q;
  logic [PosW-1:0]   s_pos_q;
  logic [SoundW-1:0] s_snd_q;

  // scan pipeline, second stage: lines up with the wave word
  logic              t_busy_q;
  logic [VoiceW-1:0] t_idx_q;
  logic [PosW-1:0]   t_pos_q;
  logic [SoundW-1:0] t_snd_q;

  logic signed [22:0] sum_q;
  logic               refuse_q;
  logic               found_q;
  logic [VoiceW-1:0]  free_q;
  logic               accepted_q;
  logic signed [15:0] mixed_q;

  logic [WaveAw-1:0] rd_addr;
  logic [PosW-1:0]   pos_inc;
  logic              voice_done;
  logic              start_ok;
  logic [5:0]        eff_limit;
  logic signed [22:0] lim_s;

  assign eff_limit  = (limit_i > 6'(MaxVoices)) ? 6'(MaxVoices) : limit_i;
  assign rd_addr    = WaveAw'(base_q[s_snd_q] + s_pos_q[15:0]);
  assign pos_inc    = t_pos_q + 1'b1;
  assign voice_done = (pos_inc >= {1'b0, size_q[t_snd_q]});
  assign start_ok   = cmd_i.do_start && found_q && !refuse_q;
  assign lim_s      = 23'(signed'({1'b0, clip_i}));

  assign stat_o.cmd         = item_q.cmd;
  assign stat_o.tick_skip   = mute_i || (count_q == '0);
  assign stat_o.play_refuse = mute_i || !def_q[item_q.sound_id]
                              || (6'(count_q) >= eff_limit);

  // wave store port
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_writes && item_q.cmd == CmdWave) begin
      wave_mem[item_q.wave_addr] <= item_q.wave_value;
    end
    wave_rd_q <= wave_mem[rd_addr];
  end

  // voice slot memory: at most one slot written per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_upd && t_busy_q) begin
      vpos_q[t_idx_q] <= voice_done ? '0 : pos_inc;
    end else if (start_ok) begin
      vsnd_q[free_q] <= item_q.sound_id;
      vpos_q[free_q] <= '0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_i;
    end
    if (cmd_i.scan_rd) begin
      s_idx_q <= cmd_i.scan_idx;
      s_pos_q <= vpos_q[cmd_i.scan_idx];
      s_snd_q <= vsnd_q[cmd_i.scan_idx];
    end
    t_idx_q <= s_idx_q;
    t_pos_q <= s_pos_q;
    t_snd_q <= s_snd_q;
  end

  // voice, descriptor and accumulation state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= '0;
      count_q    <= '0;
      def_q      <= '0;
      s_busy_q   <= 1'b0;
      t_busy_q   <= 1'b0;
      sum_q      <= '0;
      refuse_q   <= 1'b0;
      found_q    <= 1'b0;
      free_q     <= '0;
      accepted_q <= 1'b0;
      mixed_q    <= '0;
      for (int i = 0; i < NumSounds; i++) begin
        base_q[i] <= '0;
        size_q[i] <= '0;
      end
    end else begin
      t_busy_q <= s_busy_q;
      if (cmd_i.clr_sum) begin
        sum_q      <= '0;
        refuse_q   <= 1'b0;
        found_q    <= 1'b0;
        accepted_q <= 1'b0;
        s_busy_q   <= 1'b0;
      end
      if (cmd_i.scan_rd) begin
        s_busy_q <= busy_q[cmd_i.scan_idx];
      end
      // accumulate one voice and advance it
      if (cmd_i.tick_upd && t_busy_q) begin
        sum_q <= sum_q + 23'(wave_rd_q);
        if (voice_done) begin
          busy_q[t_idx_q] <= 1'b0;
          count_q         <= count_q - 1'b1;
        end
      end
      // retrigger check and lowest free slot
      if (cmd_i.play_chk) begin
        if (s_busy_q && s_snd_q == item_q.sound_id && s_pos_q < {1'b0, retrig_i}) begin
          refuse_q <= 1'b1;
        end
        if (!s_busy_q && !found_q) begin
          found_q <= 1'b1;
          free_q  <= s_idx_q;
        end
      end
      if (start_ok) begin
        busy_q[free_q] <= 1'b1;
        count_q        <= count_q + 1'b1;
        accepted_q     <= 1'b1;
      end
      if (cmd_i.do_writes && item_q.cmd == CmdSound) begin
        base_q[item_q.sound_id] <= item_q.sound_start;
        size_q[item_q.sound_id] <= item_q.sound_length;
        def_q[item_q.sound_id]  <= 1'b1;
      end
      // clamp; items other than ticks give a zero sample
      if (cmd_i.make_out) begin
        if (item_q.cmd != CmdTick) begin
          mixed_q <= '0;
        end else if (sum_q > lim_s) begin
          mixed_q <= 16'(lim_s);
        end else if (sum_q < -lim_s) begin
          mixed_q <= 16'(-lim_s);
        end else begin
          mixed_q <= 16'(sum_q);
        end
      end
    end
  end

  assign out_o.mixed_sample  = mixed_q;
  assign out_o.play_accepted = accepted_q;
  assign out_o.active_voices = 6'(count_q);

endmodule

// ===== rtl/core/svm_ctrl.sv =====
module svm_ctrl
  import svm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    StIdle, StDecode, StScan, StStart, StOut, StHold
  } state_e;

  state_e            state_q;
  logic [VoiceW:0]   idx_q;
  logic              pend1_q;  // slot read held in the first scan stage
  logic              pend2_q;  // slot and wave word held in the second stage
  logic              out_v_q;
  logic              is_tick;

  assign is_tick     = (stat_i.cmd == CmdTick);
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_v_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.scan_idx = idx_q[VoiceW-1:0];
    cmd_o.load     = (state_q == StIdle) && in_valid_i;
    cmd_o.clr_sum  = (state_q == StDecode);
    unique case (state_q)
      StScan: begin
        cmd_o.scan_rd  = (idx_q < (VoiceW+1)'(MaxVoices));
        cmd_o.tick_upd = pend2_q && is_tick;
        cmd_o.play_chk = pend1_q && !is_tick;
      end
      StStart: cmd_o.do_start  = 1'b1;
      StOut: begin
        cmd_o.make_out  = 1'b1;
        cmd_o.do_writes = 1'b1;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
      pend1_q <= 1'b0;
      pend2_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (out_v_q && out_ready_i) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: if (in_valid_i) state_q <= StDecode;
        StDecode: begin
          idx_q   <= '0;
          pend1_q <= 1'b0;
          pend2_q <= 1'b0;
          priority if (is_tick) begin
            state_q <= stat_i.tick_skip ? StOut : StScan;
          end else if (stat_i.cmd == CmdPlay) begin
            state_q <= stat_i.play_refuse ? StOut : StScan;
          end else begin
            state_q <= StOut;
          end
        end
        StScan: begin
          pend1_q <= cmd_o.scan_rd;
          pend2_q <= pend1_q;
          if (cmd_o.scan_rd) begin
            idx_q <= idx_q + 1'b1;
          end else if (!pend1_q) begin
            state_q <= is_tick ? StOut : StStart;
          end
        end
        StStart: state_q <= StOut;
        StOut: begin
          out_v_q <= 1'b1;
          state_q <= StHold;
        end
        StHold: if (!out_v_q || out_ready_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== rtl/core/svm_checker.sv =====
module svm_checker
  import svm_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input out_word_t  out_data_i
);

  // no new word while a result is pending
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("input taken with result pending");

  // a taken word closes the input
  a_accept_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input still open after a word was taken");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result dropped");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.active_voices <= 6'(MaxVoices))
    else $error("voice count out of range");

  a_play_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.play_accepted |-> out_data_i.mixed_sample == '0)
    else $error("play result with a sample");

endmodule

bind saturating_voice_mixer_core svm_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid_i (in_if.valid),
  .in_ready_i (in_if.ready),
  .out_valid_i(out_if.valid),
  .out_ready_i(out_if.ready),
  .out_data_i (out_if.data)
);

// ===== verif/tb_saturating_voice_mixer_core.sv =====
module tb_saturating_voice_mixer_core;
  import svm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Mixer state mirror: predicts one result word per accepted input word
  class mix_scoreboard;
    bit              cfg_mute;
    bit [5:0]        cfg_limit;
    bit [15:0]       cfg_retrig;
    bit [14:0]       cfg_clip;
    bit              busy [MaxVoices];
    bit [3:0]        vsound [MaxVoices];
    bit [16:0]       vpos [MaxVoices];
    int unsigned     nbusy;
    bit signed [15:0] wave [int unsigned];
    bit [15:0]       sbase [NumSounds];
    bit [15:0]       ssize [NumSounds];
    bit              sdef [NumSounds];
    out_word_t       pending [$];
    int unsigned     errors, checked, ticks, plays_ok;

    function new();
      cfg_mute = 0; cfg_limit = ResetVoiceLimit;
      cfg_retrig = ResetRetrig; cfg_clip = ResetClip;
      nbusy = 0;
      foreach (busy[v]) begin
        busy[v] = 0; vsound[v] = 0; vpos[v] = 0;
      end
      foreach (sdef[s]) begin
        sdef[s] = 0; sbase[s] = 0; ssize[s] = 0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        RegMute:   cfg_mute = val[0];
        RegLimit:  cfg_limit = val[5:0];
        RegRetrig: cfg_retrig = val;
        RegClip:   cfg_clip = val[14:0];
        default: ;
      endcase
    endfunction

    function int mix_voices();
      int sum;
      int lim;
      bit [3:0] s;
      bit [15:0] a;
      sum = 0;
      lim = cfg_clip;
      if (cfg_mute || nbusy == 0) return 0;
      for (int v = 0; v < MaxVoices; v++) begin
        if (!busy[v]) continue;
        s = vsound[v];
        a = sbase[s] + vpos[v][15:0];
        if (wave.exists(a)) sum += wave[a];
        vpos[v] = vpos[v] + 17'd1;
        if (vpos[v] >= ssize[s]) begin
          busy[v] = 0; vpos[v] = 0; nbusy--;
        end
      end
      if (sum > lim) sum = lim;
      else if (sum < -lim) sum = -lim;
      return sum;
    endfunction

    function bit start_voice(bit [3:0] s);
      int unsigned lim;
      lim = (cfg_limit > MaxVoices) ? MaxVoices : cfg_limit;
      if (!sdef[s] || cfg_mute || nbusy >= lim) return 0;
      for (int v = 0; v < MaxVoices; v++)
        if (busy[v] && vsound[v] == s && vpos[v] < cfg_retrig) return 0;
      for (int v = 0; v < MaxVoices; v++)
        if (!busy[v]) begin
          busy[v] = 1; vsound[v] = s; vpos[v] = 0; nbusy++;
          return 1;
        end
      return 0;
    endfunction

    // note an accepted input word
    function void note_input(in_word_t w);
      out_word_t r;
      r = '0;
      case (w.cmd)
        CmdTick: begin
          r.mixed_sample = 16'(mix_voices());
          ticks++;
        end
        CmdPlay: begin
          r.play_accepted = start_voice(w.sound_id);
          plays_ok += r.play_accepted;
        end
        CmdWave: wave[w.wave_addr] = w.wave_value;
        default: begin
          sbase[w.sound_id] = w.sound_start;
          ssize[w.sound_id] = w.sound_length;
          sdef[w.sound_id] = 1;
        end
      endcase
      r.active_voices = 6'(nbusy);
      pending.push_back(r);
    endfunction

    // compare a result word with the oldest expectation
    function void check_result(out_word_t got);
      out_word_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word %p", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.mixed_sample !== exp.mixed_sample) begin
        $display("%0t: mixed_sample exp %0d got %0d", $time, exp.mixed_sample,
                 got.mixed_sample);
        errors++;
      end
      if (got.play_accepted !== exp.play_accepted) begin
        $display("%0t: play_accepted exp %0b got %0b", $time, exp.play_accepted,
                 got.play_accepted);
        errors++;
      end
      if (got.active_voices !== exp.active_voices) begin
        $display("%0t: active_voices exp %0d got %0d", $time, exp.active_voices,
                 got.active_voices);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [1:0] cfg_idx_i = RegMute;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  svm_if #(in_word_t)  in_if ();
  svm_if #(out_word_t) out_if ();

  saturating_voice_mixer_core dut (
    .clk_i, .rst_ni, .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  mix_scoreboard sb = new();
  bit hold_off = 0;
  bit sink_stalls = 1;
  int idle_cycles = 0;

  initial begin
    in_if.valid = 0;
    in_if.data = '0;
    out_if.ready = 0;
  end

  // result side: random stalls plus one long hold-off
  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
  end

  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_if.ready <= 0;
        repeat (600) @(posedge clk_i);
        hold_off = 0;
      end
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 3);
      if (!sink_stalls || $urandom_range(0, 1)) g = 0;
      if (g > 0) begin
        out_if.ready <= 0;
        repeat (g) @(posedge clk_i);
      end
      out_if.ready <= 1;
      @(posedge clk_i);
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("saturating_voice_mixer_core verification failed");
      $finish;
    end
  end

  task automatic send_word(in_word_t w, bit gaps);
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 2);
    if (gaps && $urandom_range(0, 1) && g > 0) begin
      in_if.valid <= 0;
      repeat (g) @(posedge clk_i);
    end
    in_if.valid <= 1;
    in_if.data <= w;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(w);
  endtask

  task automatic finish_send();
    in_if.valid <= 0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // one register write, then the write port goes quiet
  task automatic set_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.write_reg(idx, val[15:0]);
    @(posedge clk_i);
  endtask

  function automatic in_word_t mk(logic [31:0] c, logic [31:0] s, logic [31:0] a,
                                  logic [31:0] v, logic [31:0] st, logic [31:0] len);
    in_word_t w;
    w.cmd = c[1:0]; w.sound_id = s[3:0]; w.wave_addr = a[15:0]; w.wave_value = v[15:0];
    w.sound_start = st[15:0]; w.sound_length = len[15:0];
    return w;
  endfunction

  // one random word whose reads stay inside written wave memory
  function automatic in_word_t play_mix_word(bit [15:0] wbase);
    int k;
    k = $urandom_range(0, 99);
    if (k < 45) return mk(CmdTick, $urandom, $urandom, $urandom, $urandom, $urandom);
    if (k < 80) return mk(CmdPlay, $urandom, $urandom, $urandom, $urandom, $urandom);
    if (k < 92)
      return mk(CmdWave, $urandom, wbase + $urandom_range(0, 255), $urandom,
                $urandom, $urandom);
    return mk(CmdSound, $urandom, $urandom, $urandom, wbase + $urandom_range(0, 128),
              $urandom_range(0, 127));
  endfunction

  initial begin
    bit [15:0] wbase;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: idle tick, undefined play, extremes of the wave word, lengths 0 and max
    send_word(mk(CmdTick, 0, 0, 0, 0, 0), 0);
    send_word(mk(CmdPlay, 15, 0, 0, 0, 0), 0);
    send_word(mk(CmdWave, 0, 16'hFFFF, 16'h7FFF, 0, 0), 0);
    send_word(mk(CmdWave, 0, 16'h0000, 16'h8000, 0, 0), 0);
    send_word(mk(CmdWave, 0, 16'h0001, 16'h7FFF, 0, 0), 0);
    send_word(mk(CmdSound, 0, 0, 0, 16'hFFFF, 16'd3), 0);  // wraps round the store
    send_word(mk(CmdSound, 15, 0, 0, 16'h0000, 16'd0), 0); // zero length
    send_word(mk(CmdSound, 1, 0, 0, 16'h0001, 16'hFFFF), 0);
    send_word(mk(CmdPlay, 0, 0, 0, 0, 0), 0);
    send_word(mk(CmdPlay, 0, 0, 0, 0, 0), 0);   // retrigger refused
    send_word(mk(CmdPlay, 15, 0, 0, 0, 0), 0);
    send_word(mk(CmdPlay, 1, 0, 0, 0, 0), 0);
    send_word(mk(CmdTick, 0, 0, 0, 0, 0), 0);
    send_word(mk(CmdSound, 1, 0, 0, 16'h0000, 16'd1), 0);  // shrink under a voice
    send_word(mk(CmdTick, 0, 0, 0, 0, 0), 0);
    send_word(mk(CmdTick, 0, 0, 0, 0, 0), 0);
    send_word(mk(CmdTick, 0, 0, 0, 0, 0), 0);
    finish_send();
    drain();

    // one wave window for every phase; the first phase writes all of it
    wbase = 16'($urandom);

    // random phases over several register settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin set_reg(RegMute, 0); set_reg(RegLimit, 48); set_reg(RegRetrig, 0);
                 set_reg(RegClip, 16'h7FFF); end
        1: begin set_reg(RegLimit, 63); set_reg(RegRetrig, 16'hFFFF);
                 set_reg(RegClip, 0); end
        2: begin set_reg(RegLimit, 0); set_reg(RegRetrig, 3); set_reg(RegClip, 1000); end
        3: begin set_reg(RegMute, 1); set_reg(RegLimit, 5); end
        4: begin set_reg(RegMute, 0); set_reg(RegLimit, 48); set_reg(RegRetrig, 2);
                 set_reg(RegClip, 32760); end
        default: begin set_reg(RegLimit, $urandom_range(1, 63));
                 set_reg(RegRetrig, $urandom_range(0, 20));
                 set_reg(RegClip, $urandom_range(0, 32767)); end
      endcase
      // write the window that every descriptor below reads from: all of it in the first phase, a random part after
      for (int i = 0; i < 256; i++)
        if (ph == 0 || $urandom_range(0, 31) == 0)
          send_word(mk(CmdWave, $urandom, wbase + i, $urandom, 0, 0), i > 200);
      for (int s = 0; s < NumSounds; s++)
        send_word(mk(CmdSound, s, 0, 0, wbase + $urandom_range(0, 128),
                     $urandom_range(0, 127)), 1);
      if (ph == 5) hold_off = 1;
      sink_stalls = (ph != 6);
      for (int i = 0; i < 80; i++) send_word(play_mix_word(wbase), ph != 6);
      finish_send();
      drain();
    end
    set_reg(RegMute, 0);

    $display("Covered %0d results: %0d ticks, %0d voices started, 8 register settings.",
             sb.checked, sb.ticks, sb.plays_ok);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("saturating_voice_mixer_core verification clean");
    else
      $display("saturating_voice_mixer_core verification failed");
    $finish;
  end
endmodule
